// ----- src/hnm_pkg.sv -----
// ============================================================================
// hnm_pkg: shared types and constants of the height-to-normal-map block
// Holds the sequencer states, the arithmetic unit commands, the register
// indexes and the fixed field widths used by more than one file.
// ============================================================================
package hnm_pkg;

    // Field widths fixed by the interface.
    localparam int HEIGHT_W  = 8;
    localparam int GAIN_W    = 8;
    localparam int IMG_W_W   = 13;
    localparam int NORM_W    = 8;
    localparam int COL_OUT_W = 12;
    localparam int ROW_W     = 16;
    localparam int CFG_W     = 13;

    // Datapath widths of the arithmetic unit.
    localparam int MAG_W   = 16;  // |P-X|*gain
    localparam int SUM_W   = 33;  // dx^2 + dy^2 + 256
    localparam int NUM_W   = 24;  // 255*|c|
    localparam int REM_W   = 48;  // (255*|c|)^2 and division remainder
    localparam int QUO_W   = 14;  // quotient, below 16257
    localparam int ROOT_W  = 7;   // square root of the quotient
    localparam int STEP_W  = 4;
    localparam int DIV_SHIFT = 15; // 4*S aligned to the top quotient bit

    localparam logic [STEP_W-1:0] DIV_LAST  = 4'd13;
    localparam logic [STEP_W-1:0] SQRT_LAST = 4'd6;

    localparam logic [MAG_W-1:0]  Z_MAG     = 16'd16;   // 1.0 in 1/16 units
    localparam logic [SUM_W-1:0]  Z_SQUARE  = 33'd256;
    localparam logic [NUM_W-1:0]  FULL_SCALE = 24'd255;
    localparam logic [NORM_W-1:0] MID_CODE  = 8'd128;

    // Configuration register indexes and reset values.
    typedef logic [0:0] t_cfg_index;
    localparam t_cfg_index CFG_IMAGE_WIDTH = 1'b0;
    localparam t_cfg_index CFG_GAIN        = 1'b1;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET = 13'd256;
    localparam logic [GAIN_W-1:0]  GAIN_RESET        = 8'd32;

    typedef enum logic [1:0] {
        COMP_X,
        COMP_Y,
        COMP_Z
    } t_comp;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_MDX,
        OP_MDY,
        OP_SQX,
        OP_SQY,
        OP_MA1,
        OP_MA2,
        OP_DIV,
        OP_SQI,
        OP_SQRT,
        OP_FIN
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_MDX,
        S_MDY,
        S_SQX,
        S_SQY,
        S_MA1,
        S_MA2,
        S_DIV,
        S_SQI,
        S_SQRT,
        S_FIN,
        S_DONE
    } t_state;

    typedef struct packed {
        t_op   op;
        t_comp comp;
    } t_arith_cmd;

    typedef struct packed {
        logic [NORM_W-1:0] x;
        logic [NORM_W-1:0] y;
        logic [NORM_W-1:0] z;
    } t_normal;

endpackage

// ----- src/hnm_ram.sv -----
// ============================================================================
// hnm_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
module hnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/hnm_arith.sv -----
// ============================================================================
// hnm_arith: shared arithmetic unit of the normal computation
// One multiplier and one wide subtractor, driven step by step by the
// sequencer: slopes, squared length, then per component a restoring
// division and a digit-by-digit square root.
// ============================================================================
module hnm_arith (
    input  logic                                i_clk,
    input  hnm_pkg::t_arith_cmd                 i_cmd,
    input  logic [hnm_pkg::HEIGHT_W-1:0]        i_p,
    input  logic [hnm_pkg::HEIGHT_W-1:0]        i_x,
    input  logic [hnm_pkg::HEIGHT_W-1:0]        i_cur,
    input  logic [hnm_pkg::GAIN_W-1:0]          i_gain,
    output hnm_pkg::t_normal                    o_normal
);

    logic [hnm_pkg::MAG_W-1:0]  r_dx;
    logic [hnm_pkg::MAG_W-1:0]  r_dy;
    logic [hnm_pkg::SUM_W-1:0]  r_s;
    logic [hnm_pkg::NUM_W-1:0]  r_num;
    logic [hnm_pkg::REM_W-1:0]  r_rem;
    logic [hnm_pkg::REM_W-1:0]  r_div;
    logic [hnm_pkg::QUO_W-1:0]  r_q;
    logic [hnm_pkg::QUO_W-1:0]  r_rad;
    logic [hnm_pkg::ROOT_W-1:0] r_root;
    logic                       r_exact;
    hnm_pkg::t_normal           r_normal;

    logic [hnm_pkg::HEIGHT_W-1:0] diff_px;
    logic [hnm_pkg::HEIGHT_W-1:0] diff_pc;
    logic [hnm_pkg::MAG_W-1:0]    comp_mag;
    logic                         comp_neg;
    logic [hnm_pkg::NUM_W-1:0]    mul_a;
    logic [hnm_pkg::NUM_W-1:0]    mul_b;
    logic [hnm_pkg::REM_W-1:0]    prod;
    logic [hnm_pkg::REM_W-1:0]    sub_a;
    logic [hnm_pkg::REM_W-1:0]    sub_b;
    logic [hnm_pkg::REM_W:0]      diff;
    logic                         ge;
    logic                         inexact;
    logic [hnm_pkg::NORM_W-1:0]   code_up;
    logic [hnm_pkg::NORM_W-1:0]   code_down;
    logic [hnm_pkg::NORM_W-1:0]   code;

    assign diff_px = (i_p >= i_x)   ? (i_p - i_x)   : (i_x - i_p);
    assign diff_pc = (i_p >= i_cur) ? (i_p - i_cur) : (i_cur - i_p);

    // Magnitude and sign of the component being mapped.
    always_comb begin
        unique case (i_cmd.comp)
            hnm_pkg::COMP_X: begin
                comp_mag = r_dx;
                comp_neg = (i_p < i_x);
            end
            hnm_pkg::COMP_Y: begin
                comp_mag = r_dy;
                comp_neg = (i_p < i_cur);
            end
            default: begin
                comp_mag = hnm_pkg::Z_MAG;
                comp_neg = 1'b0;
            end
        endcase
    end

    // Operand selection of the shared multiplier.
    always_comb begin
        unique case (i_cmd.op)
            hnm_pkg::OP_MDX: begin
                mul_a = hnm_pkg::NUM_W'(diff_px);
                mul_b = hnm_pkg::NUM_W'(i_gain);
            end
            hnm_pkg::OP_MDY: begin
                mul_a = hnm_pkg::NUM_W'(diff_pc);
                mul_b = hnm_pkg::NUM_W'(i_gain);
            end
            hnm_pkg::OP_SQX: begin
                mul_a = hnm_pkg::NUM_W'(r_dx);
                mul_b = hnm_pkg::NUM_W'(r_dx);
            end
            hnm_pkg::OP_SQY: begin
                mul_a = hnm_pkg::NUM_W'(r_dy);
                mul_b = hnm_pkg::NUM_W'(r_dy);
            end
            hnm_pkg::OP_MA1: begin
                mul_a = hnm_pkg::NUM_W'(comp_mag);
                mul_b = hnm_pkg::FULL_SCALE;
            end
            hnm_pkg::OP_MA2: begin
                mul_a = r_num;
                mul_b = r_num;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = {{hnm_pkg::NUM_W{1'b0}}, mul_a} * {{hnm_pkg::NUM_W{1'b0}}, mul_b};

    // Operand selection of the shared subtractor: a division step or a
    // square root step.
    always_comb begin
        if (i_cmd.op == hnm_pkg::OP_SQRT) begin
            sub_a = {r_rem[hnm_pkg::REM_W-3:0], r_rad[hnm_pkg::QUO_W-1 -: 2]};
            sub_b = hnm_pkg::REM_W'({r_root, 2'b01});
        end else begin
            sub_a = r_rem;
            sub_b = r_div;
        end
    end

    assign diff = {1'b0, sub_a} - {1'b0, sub_b};
    assign ge   = ~diff[hnm_pkg::REM_W];

    // The exact value is 128 + 255*c/(2L); a negative component whose
    // scaled value is not an integer rounds one further down.
    assign inexact   = ~(r_exact && (r_rem == '0));
    assign code_up   = hnm_pkg::MID_CODE + hnm_pkg::NORM_W'(r_root);
    assign code_down = hnm_pkg::MID_CODE - hnm_pkg::NORM_W'(r_root)
                       - hnm_pkg::NORM_W'(inexact);
    assign code      = comp_neg ? code_down : code_up;

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            hnm_pkg::OP_NONE: begin
            end
            hnm_pkg::OP_MDX: begin
                r_dx <= prod[hnm_pkg::MAG_W-1:0];
            end
            hnm_pkg::OP_MDY: begin
                r_dy <= prod[hnm_pkg::MAG_W-1:0];
            end
            hnm_pkg::OP_SQX: begin
                r_s <= hnm_pkg::SUM_W'(prod[2*hnm_pkg::MAG_W-1:0]) + hnm_pkg::Z_SQUARE;
            end
            hnm_pkg::OP_SQY: begin
                r_s <= r_s + hnm_pkg::SUM_W'(prod[2*hnm_pkg::MAG_W-1:0]);
            end
            hnm_pkg::OP_MA1: begin
                r_num <= prod[hnm_pkg::NUM_W-1:0];
            end
            hnm_pkg::OP_MA2: begin
                r_rem <= prod;
                r_div <= {r_s, {hnm_pkg::DIV_SHIFT{1'b0}}};
                r_q   <= '0;
            end
            hnm_pkg::OP_DIV: begin
                if (ge) begin
                    r_rem <= diff[hnm_pkg::REM_W-1:0];
                end
                r_q   <= {r_q[hnm_pkg::QUO_W-2:0], ge};
                r_div <= r_div >> 1;
            end
            hnm_pkg::OP_SQI: begin
                r_exact <= (r_rem == '0);
                r_rem   <= '0;
                r_root  <= '0;
                r_rad   <= r_q;
            end
            hnm_pkg::OP_SQRT: begin
                r_rem  <= ge ? diff[hnm_pkg::REM_W-1:0] : sub_a;
                r_root <= {r_root[hnm_pkg::ROOT_W-2:0], ge};
                r_rad  <= {r_rad[hnm_pkg::QUO_W-3:0], 2'b00};
            end
            hnm_pkg::OP_FIN: begin
                unique case (i_cmd.comp)
                    hnm_pkg::COMP_X: r_normal.x <= code;
                    hnm_pkg::COMP_Y: r_normal.y <= code;
                    default:         r_normal.z <= code;
                endcase
            end
            default: begin
            end
        endcase
    end

    assign o_normal = r_normal;

endmodule

// ----- src/height_to_normal_map.sv -----
// ============================================================================
// height_to_normal_map: forward-difference normal map from a height stream
// Height pixels arrive in raster order; start_of_frame puts a pixel at
// column 0, row 0. One row of heights is kept in a RAM of MAX_WIDTH
// entries. For a pixel P with right neighbor X and lower neighbor Y the
// block normalizes ((P-X)*gain, (P-Y)*gain, 1), gain in unsigned Q4.4, and
// maps each component to round((c*0.5+0.5)*255) exactly, ties up. The
// normal of P is delivered when Y arrives, tagged with P's column and row;
// the last column and the last row give no result. A pixel that gives no
// normal occupies the input for its transfer and the two RAM reads. A
// pixel that gives a normal occupies it also for the slopes and the
// squared length, then per component for the shared multiplier and
// subtractor (14 division steps and 7 square root steps dominate), and
// to hand the result to the output register; the next pixel is taken
// while that result waits. The image_width register is clamped to
// 2..MAX_WIDTH; both registers should be written only while the block
// is idle.
// ============================================================================
module height_to_normal_map #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  hnm_pkg::t_cfg_index              i_cfg_index,
    input  logic [hnm_pkg::CFG_W-1:0]        i_cfg_data,
    // Height pixel input.
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [hnm_pkg::HEIGHT_W-1:0]     i_height,
    input  logic                             i_start_of_frame,
    // Normal output.
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [hnm_pkg::NORM_W-1:0]       o_normal_x,
    output logic [hnm_pkg::NORM_W-1:0]       o_normal_y,
    output logic [hnm_pkg::NORM_W-1:0]       o_normal_z,
    output logic [hnm_pkg::COL_OUT_W-1:0]    o_pixel_col,
    output logic [hnm_pkg::ROW_W-1:0]        o_pixel_row
);

    // CW indexes the row RAM; EW also holds the width itself.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = $clog2(MAX_WIDTH + 1);

    // Control and configuration state.
    hnm_pkg::t_state                 r_state, n_state;
    logic [hnm_pkg::STEP_W-1:0]      r_step, n_step;
    hnm_pkg::t_comp                  r_comp, n_comp;
    logic [CW-1:0]                   r_col;
    logic [hnm_pkg::ROW_W-1:0]       r_row;
    logic [hnm_pkg::IMG_W_W-1:0]     r_image_width;
    logic [hnm_pkg::GAIN_W-1:0]      r_gain;
    logic                            r_produce;
    logic                            r_out_valid;

    // Per-pixel payload.
    logic [CW-1:0]                   r_wcol;
    logic [hnm_pkg::ROW_W-1:0]       r_orow;
    logic [hnm_pkg::HEIGHT_W-1:0]    r_cur;
    logic [hnm_pkg::HEIGHT_W-1:0]    r_p;
    logic [hnm_pkg::HEIGHT_W-1:0]    r_x;
    hnm_pkg::t_normal                r_out_normal;
    logic [CW-1:0]                   r_out_col;
    logic [hnm_pkg::ROW_W-1:0]       r_out_row;

    logic                            in_xfer;
    logic                            out_free;
    logic                            out_load;
    logic [31:0]                     w_raw;
    logic [EW-1:0]                   eff_w;
    logic [CW-1:0]                   col0, col1, col_after;
    logic [EW-1:0]                   col1_inc;
    logic [hnm_pkg::ROW_W-1:0]       row0, row1, row_after;
    logic                            produce;
    logic [CW-1:0]                   wcol_next;
    logic [CW-1:0]                   ram_raddr;
    logic                            ram_we;
    logic [hnm_pkg::HEIGHT_W-1:0]    ram_rdata;
    hnm_pkg::t_arith_cmd             arith_cmd;
    hnm_pkg::t_normal                arith_normal;
    logic [31:0]                     out_col_ext;

    assign in_xfer  = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // ------------------------------------------------------------------
    // Position tracking. The configured width is clamped into the range
    // the row RAM can hold. A start of frame restarts at the origin, and
    // a column that is no longer inside a narrowed row wraps to the next
    // row before the pixel is used.
    // ------------------------------------------------------------------
    assign w_raw = 32'(r_image_width);

    always_comb begin
        if (w_raw < 32'd2) begin
            eff_w = EW'(2);
        end else if (w_raw > 32'(MAX_WIDTH)) begin
            eff_w = EW'(MAX_WIDTH);
        end else begin
            eff_w = EW'(w_raw);
        end
    end

    always_comb begin
        col0 = i_start_of_frame ? '0 : r_col;
        row0 = i_start_of_frame ? '0 : r_row;
        if (EW'(col0) >= eff_w) begin
            col1 = '0;
            row1 = row0 + hnm_pkg::ROW_W'(1);
        end else begin
            col1 = col0;
            row1 = row0;
        end
        col1_inc = EW'(col1) + EW'(1);
        // A normal needs a right neighbor and a row above.
        produce  = (row1 != '0) && (col1_inc < eff_w);
        if (col1_inc >= eff_w) begin
            col_after = '0;
            row_after = row1 + hnm_pkg::ROW_W'(1);
        end else begin
            col_after = CW'(col1_inc);
            row_after = row1;
        end
    end

    assign wcol_next = r_wcol + CW'(1);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_comp  = r_comp;
        unique case (r_state)
            hnm_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = hnm_pkg::S_RD1;
                end
            end
            hnm_pkg::S_RD1: n_state = hnm_pkg::S_RD2;
            hnm_pkg::S_RD2: n_state = r_produce ? hnm_pkg::S_MDX : hnm_pkg::S_IDLE;
            hnm_pkg::S_MDX: n_state = hnm_pkg::S_MDY;
            hnm_pkg::S_MDY: n_state = hnm_pkg::S_SQX;
            hnm_pkg::S_SQX: n_state = hnm_pkg::S_SQY;
            hnm_pkg::S_SQY: begin
                n_state = hnm_pkg::S_MA1;
                n_comp  = hnm_pkg::COMP_X;
            end
            hnm_pkg::S_MA1: n_state = hnm_pkg::S_MA2;
            hnm_pkg::S_MA2: begin
                n_state = hnm_pkg::S_DIV;
                n_step  = '0;
            end
            hnm_pkg::S_DIV: begin
                if (r_step == hnm_pkg::DIV_LAST) begin
                    n_state = hnm_pkg::S_SQI;
                    n_step  = '0;
                end else begin
                    n_step = r_step + hnm_pkg::STEP_W'(1);
                end
            end
            hnm_pkg::S_SQI: n_state = hnm_pkg::S_SQRT;
            hnm_pkg::S_SQRT: begin
                if (r_step == hnm_pkg::SQRT_LAST) begin
                    n_state = hnm_pkg::S_FIN;
                end else begin
                    n_step = r_step + hnm_pkg::STEP_W'(1);
                end
            end
            hnm_pkg::S_FIN: begin
                if (r_comp == hnm_pkg::COMP_Z) begin
                    n_state = hnm_pkg::S_DONE;
                end else begin
                    n_state = hnm_pkg::S_MA1;
                    n_comp  = (r_comp == hnm_pkg::COMP_X) ? hnm_pkg::COMP_Y
                                                          : hnm_pkg::COMP_Z;
                end
            end
            hnm_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = hnm_pkg::S_IDLE;
                end
            end
            default: n_state = hnm_pkg::S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs. The RAM is read at the pixel's column in the
    // transfer cycle and, if the pixel gives a normal, at the next column
    // in the cycle after; the height goes to its column after both reads.
    // ------------------------------------------------------------------
    always_comb begin
        o_ready       = 1'b0;
        ram_we        = 1'b0;
        out_load      = 1'b0;
        ram_raddr     = r_wcol;
        arith_cmd.op   = hnm_pkg::OP_NONE;
        arith_cmd.comp = r_comp;
        unique case (r_state)
            hnm_pkg::S_IDLE: begin
                o_ready   = 1'b1;
                ram_raddr = col1;
            end
            hnm_pkg::S_RD1: begin
                ram_raddr = r_produce ? wcol_next : r_wcol;
            end
            hnm_pkg::S_RD2:  ram_we       = 1'b1;
            hnm_pkg::S_MDX:  arith_cmd.op = hnm_pkg::OP_MDX;
            hnm_pkg::S_MDY:  arith_cmd.op = hnm_pkg::OP_MDY;
            hnm_pkg::S_SQX:  arith_cmd.op = hnm_pkg::OP_SQX;
            hnm_pkg::S_SQY:  arith_cmd.op = hnm_pkg::OP_SQY;
            hnm_pkg::S_MA1:  arith_cmd.op = hnm_pkg::OP_MA1;
            hnm_pkg::S_MA2:  arith_cmd.op = hnm_pkg::OP_MA2;
            hnm_pkg::S_DIV:  arith_cmd.op = hnm_pkg::OP_DIV;
            hnm_pkg::S_SQI:  arith_cmd.op = hnm_pkg::OP_SQI;
            hnm_pkg::S_SQRT: arith_cmd.op = hnm_pkg::OP_SQRT;
            hnm_pkg::S_FIN:  arith_cmd.op = hnm_pkg::OP_FIN;
            hnm_pkg::S_DONE: out_load     = out_free;
            default: begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= hnm_pkg::S_IDLE;
            r_step        <= '0;
            r_comp        <= hnm_pkg::COMP_X;
            r_col         <= '0;
            r_row         <= '0;
            r_image_width <= hnm_pkg::IMAGE_WIDTH_RESET;
            r_gain        <= hnm_pkg::GAIN_RESET;
            r_produce     <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_comp  <= n_comp;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    hnm_pkg::CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                    hnm_pkg::CFG_GAIN:        r_gain <= i_cfg_data[hnm_pkg::GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (in_xfer) begin
                r_col     <= col_after;
                r_row     <= row_after;
                r_produce <= produce;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers. The output register holds a finished normal
    // while the sequencer goes on with the next pixel.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_wcol <= col1;
            r_orow <= row1 - hnm_pkg::ROW_W'(1);
            r_cur  <= i_height;
        end
        if (r_state == hnm_pkg::S_RD1) begin
            r_p <= ram_rdata;
        end
        if (r_state == hnm_pkg::S_RD2) begin
            r_x <= ram_rdata;
        end
        if (out_load) begin
            r_out_normal <= arith_normal;
            r_out_col    <= r_wcol;
            r_out_row    <= r_orow;
        end
    end

    hnm_ram #(
        .WIDTH (hnm_pkg::HEIGHT_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wcol),
        .i_wdata (r_cur),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    hnm_arith u_arith (
        .i_clk    (i_clk),
        .i_cmd    (arith_cmd),
        .i_p      (r_p),
        .i_x      (r_x),
        .i_cur    (r_cur),
        .i_gain   (r_gain),
        .o_normal (arith_normal)
    );

    // The column reported is the low 12 bits of the RAM index.
    assign out_col_ext = 32'(r_out_col);

    assign o_valid     = r_out_valid;
    assign o_normal_x  = r_out_normal.x;
    assign o_normal_y  = r_out_normal.y;
    assign o_normal_z  = r_out_normal.z;
    assign o_pixel_col = out_col_ext[hnm_pkg::COL_OUT_W-1:0];
    assign o_pixel_row = r_out_row;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // A new result only enters the output register from the final state.
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == hnm_pkg::S_DONE))
        else $error("output register loaded outside the final state");

    // A finished normal waits while the output register is still occupied.
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hnm_pkg::S_DONE && r_out_valid && !i_ready)
        |=> (r_state == hnm_pkg::S_DONE))
        else $error("sequencer left the final state with the output blocked");

    // The z component is positive, so its code never falls below the middle.
    a_z_upper_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_normal_z >= hnm_pkg::MID_CODE))
        else $error("z component mapped below the middle code");

    // The square root never runs past its last step.
    a_sqrt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hnm_pkg::S_SQRT) |-> (r_step <= hnm_pkg::SQRT_LAST))
        else $error("square root step counter out of range");

endmodule

// ----- tb/height_to_normal_map_test.sv -----
// ============================================================================
// height_to_normal_map_test: self-checking bench for the normal map block
// Streams height pixels into the block through a bursty valid/ready sender.
// A stalling receiver takes the normals out. Every normal is predicted with
// exact integer arithmetic and compared field by field with the oldest
// prediction still waiting.
// ============================================================================
module height_to_normal_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH       = 4096;
    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int SETTLE_CYCLES    = 100;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int RANDOM_PIXELS    = 920;
    localparam int REPORT_LINES     = 100;

    // Height profiles for the random pixel stream.
    localparam int HEIGHTS_ANY     = 0;
    localparam int HEIGHTS_SMOOTH  = 1;
    localparam int HEIGHTS_EXTREME = 2;

    // One pixel waiting to be offered. When hold is set, the sender waits
    // until every normal predicted so far has been delivered.
    typedef struct packed {
        logic [hnm_pkg::HEIGHT_W-1:0] height;
        logic                         sof;
        logic                         hold;
    } t_pixel_item;

    typedef struct packed {
        logic [hnm_pkg::NORM_W-1:0]    x;
        logic [hnm_pkg::NORM_W-1:0]    y;
        logic [hnm_pkg::NORM_W-1:0]    z;
        logic [hnm_pkg::COL_OUT_W-1:0] col;
        logic [hnm_pkg::ROW_W-1:0]     row;
    } t_normal_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_we = 1'b0;
    hnm_pkg::t_cfg_index           i_cfg_index = hnm_pkg::CFG_IMAGE_WIDTH;
    logic [hnm_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_valid = 1'b0;
    logic                          o_ready;
    logic [hnm_pkg::HEIGHT_W-1:0]  i_height = '0;
    logic                          i_start_of_frame = 1'b0;
    logic                          o_valid;
    logic                          i_ready = 1'b0;
    logic [hnm_pkg::NORM_W-1:0]    o_normal_x;
    logic [hnm_pkg::NORM_W-1:0]    o_normal_y;
    logic [hnm_pkg::NORM_W-1:0]    o_normal_z;
    logic [hnm_pkg::COL_OUT_W-1:0] o_pixel_col;
    logic [hnm_pkg::ROW_W-1:0]     o_pixel_row;

    height_to_normal_map #(
        .MAX_WIDTH(LINE_DEPTH)
    ) uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_height         (i_height),
        .i_start_of_frame (i_start_of_frame),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_normal_x       (o_normal_x),
        .o_normal_y       (o_normal_y),
        .o_normal_z       (o_normal_z),
        .o_pixel_col      (o_pixel_col),
        .o_pixel_row      (o_pixel_row)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Bookkeeping shared by the stimulus, the sender and the receiver.
    // ------------------------------------------------------------------------
    t_pixel_item  pending_pixels[$];
    t_normal_item expected_normals[$];
    int           pixels_queued = 0;
    int           pixels_accepted = 0;
    int           mismatches = 0;
    int unsigned  cycle_count = 0;
    int           long_holds_asked = 0;

    // Directed height patterns. The first one puts every pair of extreme
    // heights into both the right and the lower difference, so both slopes
    // reach their largest magnitude with either sign.
    byte unsigned edge_heights[12] = '{255, 0, 255, 0, 255, 0, 255, 255, 0, 0, 0, 255};
    byte unsigned flat_heights[6]  = '{17, 200, 3, 90, 90, 90};
    byte unsigned pair_heights[6]  = '{0, 255, 255, 0, 128, 128};

    // ------------------------------------------------------------------------
    // Predictor state: the line of previous heights, the raster position of
    // the next pixel and a private copy of both registers.
    // ------------------------------------------------------------------------
    logic [hnm_pkg::HEIGHT_W-1:0] line_heights[LINE_DEPTH];
    int                           next_col = 0;
    logic [hnm_pkg::ROW_W-1:0]    next_row = '0;
    logic [hnm_pkg::IMG_W_W-1:0]  width_reg = hnm_pkg::IMAGE_WIDTH_RESET;
    logic [hnm_pkg::GAIN_W-1:0]   gain_reg = hnm_pkg::GAIN_RESET;

    // The width register is clamped to the range the line store can hold.
    function automatic int effective_width(input logic [hnm_pkg::IMG_W_W-1:0] w);
        if (w < 2)
            return 2;
        if (w > LINE_DEPTH)
            return LINE_DEPTH;
        return int'(w);
    endfunction

    // True when a >= m * sqrt(s). Both sides are squared only when their
    // signs agree, so the test is exact.
    function automatic bit clears_level(input longint a, input longint m,
                                        input longint unsigned s);
        longint unsigned mag_a;
        longint unsigned mag_m;
        mag_a = (a < 0) ? -a : a;
        mag_m = (m < 0) ? -m : m;
        if (m >= 0)
            return (a >= 0) && (mag_a * mag_a >= mag_m * mag_m * s);
        return (a >= 0) || (mag_a * mag_a <= mag_m * mag_m * s);
    endfunction

    // Code of one component c of a vector of length sqrt(s): the number of
    // thresholds (2k-256)/255 * length, k = 1..255, that c reaches. This is
    // round((c/len*0.5+0.5)*255) with ties going up.
    function automatic logic [hnm_pkg::NORM_W-1:0] map_to_code(input longint c,
                                                               input longint unsigned s);
        longint scaled;
        int     code;
        scaled = 255 * c;
        code = 0;
        for (int k = 1; k <= 255; k++) begin
            if (!clears_level(scaled, 2 * k - 256, s))
                break;
            code++;
        end
        return code[hnm_pkg::NORM_W-1:0];
    endfunction

    // Steps the raster position for one transferred pixel and, when the
    // pixel lies below a pixel that has a right neighbor, queues that
    // pixel's normal.
    task automatic predict_normal(input logic [hnm_pkg::HEIGHT_W-1:0] cur,
                                  input logic sof);
        int              w;
        int              col;
        longint          p;
        longint          x;
        longint          y;
        longint          g;
        longint          dx;
        longint          dy;
        longint unsigned s;
        t_normal_item    n;
        w = effective_width(width_reg);
        if (sof) begin
            next_col = 0;
            next_row = '0;
        end
        // A width lowered in the middle of a row closes that row first.
        if (next_col >= w) begin
            next_col = 0;
            next_row = next_row + 1'b1;
        end
        col = next_col;
        if (next_row != 0 && col + 1 < w) begin
            p = longint'(line_heights[col]);
            x = longint'(line_heights[col + 1]);
            y = longint'(cur);
            g = longint'(gain_reg);
            dx = (p - x) * g;
            dy = (p - y) * g;
            // Slopes are in 1/16 units, so the z component of 1.0 is 16.
            s = dx * dx + dy * dy + 256;
            n.x = map_to_code(dx, s);
            n.y = map_to_code(dy, s);
            n.z = map_to_code(16, s);
            n.col = col[hnm_pkg::COL_OUT_W-1:0];
            n.row = next_row - 1'b1;
            expected_normals.push_back(n);
        end
        line_heights[col] = cur;
        next_col = col + 1;
        if (next_col >= w) begin
            next_col = 0;
            next_row = next_row + 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_LINES)
            $display("[cycle %0d] mismatch: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input t_normal_item ref_item);
        if (got !== want)
            report_mismatch($sformatf("pixel col %0d row %0d: %s is %0d, expected %0d",
                                      ref_item.col, ref_item.row, name, got, want));
    endtask

    task automatic check_normal();
        t_normal_item want;
        if (expected_normals.size() == 0) begin
            report_mismatch($sformatf("normal for col %0d row %0d with none expected",
                                      o_pixel_col, o_pixel_row));
            return;
        end
        want = expected_normals.pop_front();
        check_field("normal_x", int'(o_normal_x), int'(want.x), want);
        check_field("normal_y", int'(o_normal_y), int'(want.y), want);
        check_field("normal_z", int'(o_normal_z), int'(want.z), want);
        check_field("pixel_col", int'(o_pixel_col), int'(want.col), want);
        check_field("pixel_row", int'(o_pixel_row), int'(want.row), want);
    endtask

    // ------------------------------------------------------------------------
    // Sender. Offers pixels from the pending queue in bursts of random
    // length with random gaps; some bursts run long with no gap at all.
    // A pixel marked hold is not offered until every predicted normal has
    // come out. Prediction happens at the edge of the transfer itself, so
    // the predictor sees the pixels exactly in the order the block takes them.
    // ------------------------------------------------------------------------
    int          burst_left = 0;
    int          gap_left = 0;
    t_pixel_item next_pixel;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_normal(i_height, i_start_of_frame);
                pixels_accepted++;
            end
            // The payload may change only once the current transfer is done.
            if (!i_valid || o_ready) begin
                if (burst_left == 0) begin
                    if ($urandom_range(0, 3) == 0) begin
                        gap_left = 0;
                        burst_left = $urandom_range(40, 120);
                    end else begin
                        gap_left = $urandom_range(1, 12);
                        burst_left = $urandom_range(1, 16);
                    end
                end
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_pixels.size() != 0 &&
                             !(pending_pixels[0].hold && expected_normals.size() != 0)) begin
                    next_pixel = pending_pixels.pop_front();
                    i_valid <= 1'b1;
                    i_height <= next_pixel.height;
                    i_start_of_frame <= next_pixel.sof;
                    burst_left--;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver. Checks every transfer on the normal side, then picks its
    // ready for the next cycle from a rotating stall pattern that is redrawn
    // at random intervals. On request it holds ready low for a long
    // stretch, which lets the block fill up and stall its input.
    // ------------------------------------------------------------------------
    int          long_holds_given = 0;
    int          long_hold_left = 0;
    int          pattern_left = 0;
    logic [15:0] stall_pattern = '1;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                check_normal();
            if (long_hold_left > 0) begin
                long_hold_left--;
                i_ready <= 1'b0;
            end else if (long_holds_given != long_holds_asked) begin
                long_holds_given++;
                long_hold_left = LONG_HOLD_CYCLES;
                i_ready <= 1'b0;
            end else begin
                if (pattern_left == 0) begin
                    pattern_left = $urandom_range(50, 300);
                    case ($urandom_range(0, 3))
                        0: stall_pattern = '1;
                        1: stall_pattern = 16'($urandom);
                        2: stall_pattern = 16'($urandom | $urandom);
                        default: stall_pattern = 16'(($urandom & $urandom) | 32'h0001);
                    endcase
                end
                pattern_left--;
                i_ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
            end
        end
    end

    // Watchdog: ends the run as a failure once the cycle count passes CYCLE_LIMIT.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** height_to_normal_map: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------
    task automatic write_register(input hnm_pkg::t_cfg_index idx,
                                  input logic [hnm_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == hnm_pkg::CFG_IMAGE_WIDTH)
            width_reg = data[hnm_pkg::IMG_W_W-1:0];
        else
            gain_reg = data[hnm_pkg::GAIN_W-1:0];
    endtask

    // The bits above the gain field are random; the block has to ignore them.
    task automatic set_config(input logic [hnm_pkg::IMG_W_W-1:0] width_val,
                              input logic [hnm_pkg::GAIN_W-1:0] gain_val);
        logic [hnm_pkg::CFG_W-1:0] gain_word;
        gain_word = hnm_pkg::CFG_W'($urandom);
        gain_word[hnm_pkg::GAIN_W-1:0] = gain_val;
        write_register(hnm_pkg::CFG_IMAGE_WIDTH, width_val);
        write_register(hnm_pkg::CFG_GAIN, gain_word);
    endtask

    task automatic push_pixel(input logic [hnm_pkg::HEIGHT_W-1:0] h, input logic sof,
                              input logic hold);
        t_pixel_item item;
        item.height = h;
        item.sof = sof;
        item.hold = hold;
        pending_pixels.push_back(item);
        pixels_queued++;
    endtask

    // A fresh run of pixels opens a new frame. Stray frame starts inside the
    // run restart the raster at row 0.
    task automatic push_random_pixels(input int count, input bit fresh,
                                      input bit stray_sof, input int profile);
        logic [hnm_pkg::HEIGHT_W-1:0] h;
        int                           step;
        h = hnm_pkg::HEIGHT_W'($urandom);
        for (int i = 0; i < count; i++) begin
            case (profile)
                HEIGHTS_ANY: h = hnm_pkg::HEIGHT_W'($urandom);
                HEIGHTS_SMOOTH: begin
                    step = $urandom_range(0, 8);
                    h = hnm_pkg::HEIGHT_W'(int'(h) + step - 4);
                end
                default: h = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            endcase
            push_pixel(h, (i == 0 && fresh) || (stray_sof && $urandom_range(0, 149) == 0),
                       $urandom_range(0, 49) == 0);
        end
    endtask

    // Waits until every pixel has been transferred and every normal has come
    // out, then lets the block finish any pixel that gives no normal.
    task automatic drain();
        while (pixels_accepted != pixels_queued || expected_normals.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Test sequence. Registers change only while the block is idle. A width
    // that grows opens a new frame, so no pixel ever needs a line entry that
    // was never written; a width that shrinks may continue the frame, which
    // closes the current row early when the column is already past the end.
    // Wrapping the 16-bit row counter would take 65536 rows and is left out.
    // ------------------------------------------------------------------------
    initial begin
        int                          line_width;
        int                          count;
        int                          pick;
        int                          random_pixels;
        bit                          fresh;
        logic [hnm_pkg::IMG_W_W-1:0] w_raw;
        logic [hnm_pkg::GAIN_W-1:0]  g;

        random_pixels = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: 256 pixels per row and a gain of 2.0. One full row
        // plus a few pixels of the next one.
        push_random_pixels(int'(hnm_pkg::IMAGE_WIDTH_RESET) + 8, 1'b1, 1'b0, HEIGHTS_ANY);
        drain();

        // Directed: narrow image at the largest gain with extreme heights.
        set_config(13'd3, 8'd255);
        for (int i = 0; i < 12; i++)
            push_pixel(edge_heights[i], i == 0, 1'b0);
        drain();

        // Zero gain flattens every normal; the frame simply continues.
        set_config(13'd3, 8'd0);
        for (int i = 0; i < 6; i++)
            push_pixel(flat_heights[i], 1'b0, 1'b0);
        drain();

        // A width of zero is clamped to two pixels.
        set_config(13'd0, 8'd16);
        for (int i = 0; i < 6; i++)
            push_pixel(pair_heights[i], i == 0, 1'b0);
        drain();

        // Backpressure: the receiver holds off for a long stretch while the
        // sender keeps offering, so the block fills and stalls its input.
        set_config(13'd6, 8'($urandom));
        long_holds_asked++;
        push_random_pixels(90, 1'b1, 1'b0, HEIGHTS_ANY);
        drain();

        // Width lowered mid-row, down to the lower clamp: the column is
        // already past the new end, so the row closes before the next pixel.
        set_config(13'd12, 8'($urandom));
        push_random_pixels(20, 1'b1, 1'b0, HEIGHTS_ANY);
        drain();
        set_config(13'd1, 8'($urandom));
        push_random_pixels(9, 1'b0, 1'b0, HEIGHTS_ANY);
        drain();

        // Largest register value, clamped to the full line: a new frame runs
        // a few pixels into its first row, then a narrow width closes that
        // row early and the following rows give normals.
        set_config(13'h1FFF, 8'($urandom));
        push_random_pixels(10, 1'b1, 1'b0, HEIGHTS_SMOOTH);
        drain();
        set_config(13'd6, 8'($urandom));
        push_random_pixels(12, 1'b0, 1'b0, HEIGHTS_ANY);
        drain();

        // Random phases, mostly small widths so that most pixels give normals.
        while (random_pixels < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 19);
            if (pick == 0)
                w_raw = hnm_pkg::IMG_W_W'($urandom_range(0, 1));
            else if (pick == 1)
                w_raw = hnm_pkg::IMG_W_W'($urandom_range(41, 160));
            else
                w_raw = hnm_pkg::IMG_W_W'($urandom_range(2, 24));
            pick = $urandom_range(0, 9);
            if (pick == 0)
                g = 8'd0;
            else if (pick == 1)
                g = 8'd255;
            else
                g = hnm_pkg::GAIN_W'($urandom);
            fresh = effective_width(w_raw) > effective_width(width_reg) ||
                    $urandom_range(0, 2) == 0;
            set_config(w_raw, g);
            line_width = effective_width(w_raw);
            if (line_width <= 24)
                count = line_width * $urandom_range(2, 6) + $urandom_range(0, line_width);
            else
                count = line_width + $urandom_range(2, 40);
            push_random_pixels(count, fresh, 1'b1, $urandom_range(HEIGHTS_ANY, HEIGHTS_EXTREME));
            random_pixels += count;
            drain();
        end

        if (mismatches == 0)
            $display("** height_to_normal_map: PASSED **");
        else
            $display("** height_to_normal_map: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/hnm_pkg.sv
src/hnm_ram.sv
src/hnm_arith.sv
src/height_to_normal_map.sv
tb/height_to_normal_map_test.sv
